// ===== rtl/ttip_pkg.sv =====
// ----------------------------------------------------------------------------
// ttip_pkg
// shared types, constants and character helpers for the text to integer parser
// ----------------------------------------------------------------------------
package ttip_pkg;

    // window limit on characters absorbed by one parse
    localparam int MAX_CHARS = 32;

    // field widths
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 8;
    localparam int BASE_W  = 6;
    localparam int DIGIT_W = 6;
    localparam int PROD_W  = VALUE_W + BASE_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'd1;

    localparam logic [BASE_W-1:0] BASE_RESET   = 6'd10;
    localparam logic              SIGNED_RESET = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_MALFORMED = 2'd2;

    // saturation limits
    localparam logic [VALUE_W-1:0] LIM_UMAX = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] LIM_SMIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] LIM_SMAX = 32'h7FFF_FFFF;

    localparam logic [DIGIT_W-1:0] NO_DIGIT = 6'd63;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // classified character as it travels through the queue
    typedef struct packed {
        logic               eot;
        logic               space;
        logic               sign;
        logic               minus;
        logic               zero;
        logic               hex_x;
        logic [DIGIT_W-1:0] digit;
    } t_item;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = NO_DIGIT;
        if (c >= "0" && c <= "9") begin
            d = DIGIT_W'(c - "0");
        end else if (c >= "a" && c <= "z") begin
            d = DIGIT_W'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "Z") begin
            d = DIGIT_W'(c - "A" + 8'd10);
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
               c == 8'h0C || c == 8'h0D;
    endfunction

endpackage

// ===== rtl/ttip_front.sv =====
// ----------------------------------------------------------------------------
// ttip_front
// input side: classifies each character and pushes it into the queue
// ----------------------------------------------------------------------------
module ttip_front import ttip_pkg::*; (
    input  logic              i_in_valid,
    input  logic [CHAR_W-1:0] i_text_char,
    input  logic              i_end_of_text,
    input  logic              i_q_full,
    output logic              o_in_stall,
    output logic              o_push,
    output t_item             o_item
);

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_item.eot   = i_end_of_text;
        o_item.space = is_space(i_text_char);
        o_item.sign  = (i_text_char == "+") || (i_text_char == "-");
        o_item.minus = (i_text_char == "-");
        o_item.zero  = (i_text_char == "0");
        o_item.hex_x = (i_text_char == "x");
        o_item.digit = digit_of(i_text_char);
    end

endmodule

// ===== rtl/ttip_queue.sv =====
// ----------------------------------------------------------------------------
// ttip_queue
// short fifo of classified characters between front and back
// ----------------------------------------------------------------------------
module ttip_queue import ttip_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    t_item            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]    r_count, n_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/ttip_back.sv =====
// ----------------------------------------------------------------------------
// ttip_back
// parse engine: runs the number state machine one character per cycle while
// the output register is free, and holds the result in that output register
// ----------------------------------------------------------------------------
module ttip_back import ttip_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_item                 i_item,
    input  logic                  i_item_valid,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [VALUE_W-1:0]    o_parsed_value,
    output logic [STAT_W-1:0]     o_parse_status,
    output logic [CNT_W-1:0]      o_chars_consumed
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SIGN = 3'd1;
    localparam logic [2:0] PH_ZERO = 3'd2;
    localparam logic [2:0] PH_HEXP = 3'd3;
    localparam logic [2:0] PH_DIGS = 3'd4;

    localparam logic [1:0] SG_NONE  = 2'd0;
    localparam logic [1:0] SG_PLUS  = 2'd1;
    localparam logic [1:0] SG_MINUS = 2'd2;

    localparam logic [BASE_W-1:0] B_OCT = 6'd8;
    localparam logic [BASE_W-1:0] B_DEC = 6'd10;
    localparam logic [BASE_W-1:0] B_HEX = 6'd16;
    localparam logic [BASE_W-1:0] B_MIN = 6'd2;
    localparam logic [BASE_W-1:0] B_MAX = 6'd36;

    // configuration
    logic [BASE_W-1:0]  r_number_base;
    logic               r_signed_mode;

    // parse state
    logic [2:0]         r_phase, n_phase;
    logic [BASE_W-1:0]  r_base, n_base;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic               r_ovf, n_ovf;
    logic [1:0]         r_sign, n_sign;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    // output register
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_value;
    logic [STAT_W-1:0]  r_status;
    logic [CNT_W-1:0]   r_consumed;

    // step results before the window check
    logic [2:0]         s_phase;
    logic [BASE_W-1:0]  s_base;
    logic [VALUE_W-1:0] s_acc;
    logic               s_ovf;
    logic [1:0]         s_sign;
    logic [CNT_W-1:0]   s_cnt;
    logic               s_fin, s_mal, s_end;
    logic [CNT_W-1:0]   s_consumed;

    logic               emit;
    logic               fin_req, mal_req;
    logic [CNT_W-1:0]   fin_consumed;
    logic [VALUE_W-1:0] fin_value;
    logic [STAT_W-1:0]  fin_status;

    logic [BASE_W-1:0]  start_b, start_b2, zero_b;
    logic [PROD_W-1:0]  mac;
    logic               out_free;

    // accumulator is zero until the first digit, which is loaded directly; this serves the later digits
    assign mac = PROD_W'(r_acc) * PROD_W'(r_base) + PROD_W'(i_item.digit);

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_item_valid && out_free;

    always_comb begin
        start_b  = (r_phase == PH_IDLE) ? r_number_base : r_base;
        start_b2 = (start_b == '0) ? B_DEC : start_b;
        zero_b   = (r_base == '0) ? B_OCT : r_base;
    end

    // one character step
    always_comb begin
        s_phase    = r_phase;
        s_base     = r_base;
        s_acc      = r_acc;
        s_ovf      = r_ovf;
        s_sign     = r_sign;
        s_cnt      = r_cnt;
        s_fin      = 1'b0;
        s_mal      = 1'b0;
        s_end      = 1'b0;
        s_consumed = r_cnt;
        if (i_item.eot) begin
            s_end = 1'b1;
        end else begin
            unique case (r_phase)
                PH_IDLE, PH_SIGN: begin
                    if (r_phase == PH_IDLE && i_item.space) begin
                        s_cnt = r_cnt + 1'b1;
                    end else if (r_phase == PH_IDLE && i_item.sign) begin
                        s_base  = r_number_base;
                        s_sign  = i_item.minus ? SG_MINUS : SG_PLUS;
                        s_cnt   = r_cnt + 1'b1;
                        s_phase = PH_SIGN;
                    end else if ((start_b == '0 || start_b == B_HEX) && i_item.zero) begin
                        s_base  = start_b;
                        s_cnt   = r_cnt + 1'b1;
                        s_phase = PH_ZERO;
                    end else if (start_b2 < B_MIN || start_b2 > B_MAX ||
                                 i_item.digit >= start_b2) begin
                        s_mal = 1'b1;
                    end else begin
                        s_base  = start_b2;
                        s_acc   = VALUE_W'(i_item.digit);
                        s_cnt   = r_cnt + 1'b1;
                        s_phase = PH_DIGS;
                    end
                end
                PH_ZERO: begin
                    if (i_item.hex_x) begin
                        s_base  = B_HEX;
                        s_cnt   = r_cnt + 1'b1;
                        s_phase = PH_HEXP;
                    end else begin
                        s_base  = zero_b;
                        s_phase = PH_DIGS;
                        if (i_item.digit >= zero_b) begin
                            s_fin = 1'b1;
                        end else begin
                            s_acc = VALUE_W'(i_item.digit);
                            s_cnt = r_cnt + 1'b1;
                        end
                    end
                end
                PH_HEXP: begin
                    if (i_item.digit >= B_HEX) begin
                        s_fin      = 1'b1;
                        s_consumed = r_cnt - 1'b1;
                    end else begin
                        s_acc   = VALUE_W'(i_item.digit);
                        s_cnt   = r_cnt + 1'b1;
                        s_phase = PH_DIGS;
                    end
                end
                PH_DIGS: begin
                    if (i_item.digit >= r_base) begin
                        s_fin = 1'b1;
                    end else begin
                        s_acc = mac[VALUE_W-1:0];
                        s_ovf = r_ovf || (mac[PROD_W-1:VALUE_W] != '0);
                        s_cnt = r_cnt + 1'b1;
                    end
                end
                default: begin
                    s_mal = 1'b1;
                end
            endcase
            // window limit ends the parse as end of text would
            if (!s_fin && !s_mal && s_cnt >= CNT_W'(MAX_CHARS)) begin
                s_end = 1'b1;
            end
        end
    end

    // ending: pick finish or malformed
    always_comb begin
        fin_req      = s_fin;
        mal_req      = s_mal;
        fin_consumed = s_consumed;
        if (s_end) begin
            unique case (s_phase)
                PH_ZERO, PH_DIGS: begin
                    fin_req      = 1'b1;
                    fin_consumed = s_cnt;
                end
                PH_HEXP: begin
                    fin_req      = 1'b1;
                    fin_consumed = s_cnt - 1'b1;
                end
                default: begin
                    mal_req = 1'b1;
                end
            endcase
        end
        emit = fin_req || mal_req;
    end

    // saturation and sign rules
    always_comb begin
        fin_value  = s_acc;
        fin_status = ST_OK;
        if (r_signed_mode) begin
            if (s_sign == SG_MINUS) begin
                if (s_ovf || (s_acc[VALUE_W-1] && s_acc != LIM_SMIN)) begin
                    fin_value  = LIM_SMIN;
                    fin_status = ST_RANGE;
                end else begin
                    fin_value = '0 - s_acc;
                end
            end else if (s_ovf || s_acc[VALUE_W-1]) begin
                fin_value  = LIM_SMAX;
                fin_status = ST_RANGE;
            end
        end else if (s_ovf) begin
            fin_value  = LIM_UMAX;
            fin_status = ST_RANGE;
        end else if (s_sign == SG_MINUS) begin
            fin_value = '0 - s_acc;
        end
    end

    always_comb begin
        if (o_pop && emit) begin
            n_phase = PH_IDLE;
            n_base  = '0;
            n_acc   = '0;
            n_ovf   = 1'b0;
            n_sign  = SG_NONE;
            n_cnt   = '0;
        end else if (o_pop) begin
            n_phase = s_phase;
            n_base  = s_base;
            n_acc   = s_acc;
            n_ovf   = s_ovf;
            n_sign  = s_sign;
            n_cnt   = s_cnt;
        end else begin
            n_phase = r_phase;
            n_base  = r_base;
            n_acc   = r_acc;
            n_ovf   = r_ovf;
            n_sign  = r_sign;
            n_cnt   = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_RESET;
            r_signed_mode <= SIGNED_RESET;
            r_phase       <= PH_IDLE;
            r_base        <= '0;
            r_acc         <= '0;
            r_ovf         <= 1'b0;
            r_sign        <= SG_NONE;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_NUMBER_BASE: r_number_base <= i_cfg_data[BASE_W-1:0];
                    REG_SIGNED_MODE: r_signed_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_phase <= n_phase;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_sign  <= n_sign;
            r_cnt   <= n_cnt;
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_value    <= mal_req ? '0 : fin_value;
            r_status   <= mal_req ? ST_MALFORMED : fin_status;
            r_consumed <= mal_req ? '0 : fin_consumed;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_parsed_value   = r_value;
    assign o_parse_status   = r_status;
    assign o_chars_consumed = r_consumed;

endmodule

// ===== rtl/text_to_integer_parser.sv =====
// ----------------------------------------------------------------------------
// text_to_integer_parser
// streaming strtol style parser: one character per transfer, one result per
// number, classified in the front and parsed in the back
// ----------------------------------------------------------------------------
// path: the character that ends the number is written into the queue at its
//   transfer; the parse step later pops it and loads the output register, and
//   the result shows on the output from that register
// throughput: one character per cycle while the output is not stalled; each
//   parse step is one 32x6 multiply-add; a four-entry queue absorbs output stalls
// reset: synchronous, active low; clears the queue, parse state and output
//   valid, number_base returns to 10 and signed_mode to 1
module text_to_integer_parser import ttip_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CHAR_W-1:0]     i_text_char,
    input  logic                  i_end_of_text,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [VALUE_W-1:0]    o_parsed_value,
    output logic [STAT_W-1:0]     o_parse_status,
    output logic [CNT_W-1:0]      o_chars_consumed
);

    t_item w_push_item;
    t_item w_pop_item;
    logic  w_push, w_pop, w_full, w_empty;

    ttip_front u_front (
        .i_in_valid    (i_in_valid),
        .i_text_char   (i_text_char),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (w_full),
        .o_in_stall    (o_in_stall),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    ttip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_pop_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ttip_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_item           (w_pop_item),
        .i_item_valid     (!w_empty),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_parsed_value   (o_parsed_value),
        .o_parse_status   (o_parse_status),
        .o_chars_consumed (o_chars_consumed)
    );

endmodule

// ===== rtl/ttip_checker.sv =====
// ----------------------------------------------------------------------------
// ttip_checker
// port level checks on the parser results, bound to the top level
// ----------------------------------------------------------------------------
module ttip_checker import ttip_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic [VALUE_W-1:0] o_parsed_value,
    input  logic [STAT_W-1:0]  o_parse_status,
    input  logic [CNT_W-1:0]   o_chars_consumed
);

    // malformed results carry nothing
    a_malformed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_parse_status == ST_MALFORMED) |->
            (o_parsed_value == '0 && o_chars_consumed == '0))
        else $error("malformed result with non-zero value or length");

    // saturated results sit on one of the limits
    a_range_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_parse_status == ST_RANGE) |->
            (o_parsed_value == LIM_UMAX || o_parsed_value == LIM_SMIN ||
             o_parsed_value == LIM_SMAX))
        else $error("out of range result not at a limit");

    // a good number consumes at least one character, never more than the window
    a_len_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_parse_status == ST_OK || o_parse_status == ST_RANGE)) |->
            (o_chars_consumed != '0 && o_chars_consumed <= CNT_W'(MAX_CHARS)))
        else $error("consumed length outside the window");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_parsed_value) && $stable(o_parse_status) &&
             $stable(o_chars_consumed)))
        else $error("stalled result changed");

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_parsed_value   (o_parsed_value),
    .o_parse_status   (o_parse_status),
    .o_chars_consumed (o_chars_consumed)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb - text_to_integer_parser
// Streams characters into the parser and predicts every number it should
// report. The prediction is a cycle-free model of the parse inside this
// bench. It runs directed strings first, then random well-formed numbers mixed
// with noise. Phases sweep the radix and the saturation mode, and stalls fall
// on both channels.
// ----------------------------------------------------------------------------
module tb;
    import ttip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES = 9;
    localparam int CHARS_PER_PHASE = 84;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd2;

    typedef enum logic [2:0] {
        SCAN_SPACE,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_PREFIX,
        SCAN_DIGITS
    } t_scan;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eot;
    } t_char;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [STAT_W-1:0]  status;
        logic [CNT_W-1:0]   count;
    } t_number;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [CHAR_W-1:0]     i_text_char = '0;
    logic                  i_end_of_text = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [VALUE_W-1:0]    o_parsed_value;
    logic [STAT_W-1:0]     o_parse_status;
    logic [CNT_W-1:0]      o_chars_consumed;

    text_to_integer_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_text_char     (i_text_char),
        .i_end_of_text   (i_end_of_text),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_parsed_value  (o_parsed_value),
        .o_parse_status  (o_parse_status),
        .o_chars_consumed(o_chars_consumed)
    );

    always #10 i_clk = ~i_clk;

    t_char   pending_chars[$];
    t_number expected_numbers[$];
    int      fault_count = 0;
    int      send_gap_pct = 0;
    int      recv_stall_pct = 0;
    int      phase_chars = 0;
    int      quiet_cycles = 0;

    logic [CHAR_W-1:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    logic [BASE_W-1:0] sweep_base [RANDOM_PHASES] =
        '{6'd10, 6'd16, 6'd0, 6'd2, 6'd36, 6'd1, 6'd8, 6'd0, 6'd63};
    logic sweep_signed [RANDOM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

    // parser state as the bench sees it
    logic [BASE_W-1:0]  cfg_base;
    logic               cfg_signed;
    t_scan              scan;
    logic [BASE_W-1:0]  run_base;
    logic [VALUE_W-1:0] acc;
    logic               ovf;
    logic [1:0]         sign;
    logic [CNT_W-1:0]   taken;

    function automatic void clear_scan();
        scan = SCAN_SPACE;
        run_base = '0;
        acc = '0;
        ovf = 1'b0;
        sign = SIGN_NONE;
        taken = '0;
    endfunction

    function automatic void add_digit(input logic [DIGIT_W-1:0] d);
        logic [63:0] t;
        t = 64'(acc) * 64'(run_base) + 64'(d);
        if (t[63:32] != 32'd0) begin
            ovf = 1'b1;
        end
        acc = t[31:0];
        taken = taken + 8'd1;
    endfunction

    function automatic bit reject(output t_number r);
        r = '{'0, ST_MALFORMED, '0};
        clear_scan();
        return 1'b1;
    endfunction

    function automatic bit close_number(input logic [CNT_W-1:0] n, output t_number r);
        logic               neg;
        logic [VALUE_W-1:0] v;
        v = acc;
        neg = (sign == SIGN_MINUS);
        if (cfg_signed) begin
            if (neg) begin
                if (ovf || (v[31] && v != LIM_SMIN)) begin
                    r = '{LIM_SMIN, ST_RANGE, n};
                end else begin
                    r = '{-v, ST_OK, n};
                end
            end else if (ovf || v[31]) begin
                r = '{LIM_SMAX, ST_RANGE, n};
            end else begin
                r = '{v, ST_OK, n};
            end
        end else if (ovf) begin
            r = '{LIM_UMAX, ST_RANGE, n};
        end else begin
            r = '{neg ? -v : v, ST_OK, n};
        end
        clear_scan();
        return 1'b1;
    endfunction

    // end of text, or the window is full
    function automatic bit cut_number(output t_number r);
        case (scan)
            SCAN_ZERO, SCAN_DIGITS: begin
                return close_number(taken, r);
            end
            SCAN_PREFIX: begin
                return close_number(taken - 8'd1, r);
            end
            default: begin
                return reject(r);
            end
        endcase
    endfunction

    function automatic bit parse_char(input t_char it, output t_number r);
        logic [DIGIT_W-1:0] d;
        logic [BASE_W-1:0]  b;
        logic               start;
        r = '0;
        start = 1'b0;
        d = NO_DIGIT;
        if (it.ch >= CH_ZERO && it.ch <= CH_NINE) begin
            d = DIGIT_W'(it.ch - CH_ZERO);
        end else if (it.ch >= CH_LOW_A && it.ch <= CH_LOW_Z) begin
            d = DIGIT_W'(it.ch - CH_LOW_A + 8'd10);
        end else if (it.ch >= CH_UP_A && it.ch <= CH_UP_Z) begin
            d = DIGIT_W'(it.ch - CH_UP_A + 8'd10);
        end
        if (it.eot) begin
            return cut_number(r);
        end
        case (scan)
            SCAN_SPACE: begin
                if (it.ch == 8'h20 || (it.ch >= 8'h09 && it.ch <= 8'h0D)) begin
                    taken = taken + 8'd1;
                end else begin
                    run_base = cfg_base;
                    if (it.ch == CH_PLUS || it.ch == CH_MINUS) begin
                        sign = (it.ch == CH_MINUS) ? SIGN_MINUS : SIGN_PLUS;
                        taken = taken + 8'd1;
                        scan = SCAN_SIGN;
                    end else begin
                        start = 1'b1;
                    end
                end
            end
            SCAN_SIGN: begin
                start = 1'b1;
            end
            SCAN_ZERO: begin
                if (it.ch == CH_X) begin
                    run_base = 6'd16;
                    taken = taken + 8'd1;
                    scan = SCAN_PREFIX;
                end else begin
                    // a lone zero is a digit; in inferred base it means octal
                    if (run_base == 6'd0) begin
                        run_base = 6'd8;
                    end
                    scan = SCAN_DIGITS;
                    if (d >= run_base) begin
                        return close_number(taken, r);
                    end
                    add_digit(d);
                end
            end
            SCAN_PREFIX: begin
                // only the zero counts when no hex digit follows the x
                if (d >= 6'd16) begin
                    return close_number(taken - 8'd1, r);
                end
                add_digit(d);
                scan = SCAN_DIGITS;
            end
            default: begin
                if (d >= run_base) begin
                    return close_number(taken, r);
                end
                add_digit(d);
            end
        endcase
        if (start) begin
            b = run_base;
            if ((b == 6'd0 || b == 6'd16) && it.ch == CH_ZERO) begin
                taken = taken + 8'd1;
                scan = SCAN_ZERO;
            end else begin
                if (b == 6'd0) begin
                    b = 6'd10;
                end
                if (b < 6'd2 || b > 6'd36 || d >= b) begin
                    return reject(r);
                end
                run_base = b;
                acc = '0;
                add_digit(d);
                scan = SCAN_DIGITS;
            end
        end
        if (taken >= MAX_CHARS) begin
            return cut_number(r);
        end
        return 1'b0;
    endfunction

    // input channel: present queued characters, predict on each transfer
    always @(posedge i_clk) begin : drive_chars
        t_number res;
        t_char   nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (parse_char('{i_text_char, i_end_of_text}, res)) begin
                    expected_numbers.push_back(res);
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    nxt = pending_chars.pop_front();
                    i_text_char <= nxt.ch;
                    i_end_of_text <= nxt.eot;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // output channel: compare each transfer with the oldest prediction
    always @(posedge i_clk) begin : check_numbers
        t_number want;
        logic    bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_numbers.size() == 0) begin
                $display("%0t: unexpected result value %h status %0d count %0d", $time,
                         o_parsed_value, o_parse_status, o_chars_consumed);
                fault_count++;
            end else begin
                want = expected_numbers.pop_front();
                bad = 1'b0;
                if (o_parsed_value !== want.value) begin
                    $display("%0t: parsed_value expected %h got %h", $time,
                             want.value, o_parsed_value);
                    bad = 1'b1;
                end
                if (o_parse_status !== want.status) begin
                    $display("%0t: parse_status expected %0d got %0d", $time,
                             want.status, o_parse_status);
                    bad = 1'b1;
                end
                if (o_chars_consumed !== want.count) begin
                    $display("%0t: chars_consumed expected %0d got %0d", $time,
                             want.count, o_chars_consumed);
                    bad = 1'b1;
                end
                if (bad) begin
                    fault_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_char(input logic [CHAR_W-1:0] c, input logic e);
        pending_chars.push_back('{c, e});
        phase_chars++;
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            add_char(s[k], 1'b0);
        end
    endtask

    task automatic add_end();
        add_char(CHAR_W'($urandom_range(255)), 1'b1);
    endtask

    task automatic set_config(input logic [BASE_W-1:0] base, input logic sgn);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_NUMBER_BASE;
        i_cfg_data <= CFG_DATA_W'(base);
        @(posedge i_clk);
        i_cfg_index <= REG_SIGNED_MODE;
        i_cfg_data <= CFG_DATA_W'(sgn);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_base = base;
        cfg_signed = sgn;
    endtask

    // wait for every character and result transfer, then let the queue empty
    task automatic drain();
        do begin
            @(posedge i_clk);
        end while (pending_chars.size() != 0 || i_in_valid || expected_numbers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one number in the current radix, or a short run of noise
    task automatic add_number();
        int                eff;
        int                ndig;
        int                d;
        int                r;
        logic [CHAR_W-1:0] c;
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 4)) add_char(CHAR_W'($urandom_range(255)), 1'b0);
            if ($urandom_range(3) == 0) begin
                add_end();
            end
            return;
        end
        repeat ($urandom_range(0, 3)) add_char(blanks[$urandom_range(5)], 1'b0);
        r = $urandom_range(2);
        if (r != 0) begin
            add_char(r == 1 ? CH_PLUS : CH_MINUS, 1'b0);
        end
        eff = cfg_base;
        if (cfg_base == 6'd0) begin
            r = $urandom_range(2);
            if (r == 0) begin
                add_text("0x");
                eff = 16;
            end else if (r == 1) begin
                add_char(CH_ZERO, 1'b0);
                eff = 8;
            end else begin
                eff = 10;
            end
        end else if (cfg_base == 6'd16 && $urandom_range(1) == 1) begin
            add_text("0x");
        end
        if (eff < 2 || eff > 36) begin
            eff = 10;
        end
        if (eff == 10 && $urandom_range(9) == 0) begin
            // saturation edges of both modes
            case ($urandom_range(3))
                0: add_text("2147483647");
                1: add_text("2147483648");
                2: add_text("4294967295");
                default: add_text("4294967296");
            endcase
        end else begin
            ndig = ($urandom_range(9) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 10);
            repeat (ndig) begin
                d = $urandom_range(eff - 1);
                if (d < 10) begin
                    c = CHAR_W'(CH_ZERO + d);
                end else begin
                    c = CHAR_W'(($urandom_range(1) ? CH_LOW_A : CH_UP_A) + d - 10);
                end
                add_char(c, 1'b0);
            end
        end
        case ($urandom_range(3))
            0: add_end();
            1: add_char(CH_COMMA, 1'b0);
            2: add_char(blanks[$urandom_range(5)], 1'b0);
            default: add_char(CHAR_W'($urandom_range(255)), 1'b0);
        endcase
    endtask

    initial begin
        cfg_base = BASE_RESET;
        cfg_signed = SIGNED_RESET;
        clear_scan();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct = 14;
        recv_stall_pct = 52;

        // decimal, signed: blanks, sign, ending character, bare end, lone sign
        set_config(6'd10, 1'b1);
        add_text(" \t+7x");
        add_end();
        add_char(CH_MINUS, 1'b0);
        add_end();
        add_char(CH_NINE, 1'b0);
        add_char(8'hFF, 1'b0);
        drain();

        // inferred base, unsigned: hex, octal, prefix with no digit, negation
        set_config(6'd0, 1'b0);
        add_text("0x1F");
        add_end();
        add_text("012 ");
        add_text("0xg");
        add_text("-5,");
        drain();

        for (int k = 0; k < RANDOM_PHASES; k++) begin
            if (k < 3) begin
                send_gap_pct = 14;
                recv_stall_pct = 52;
            end else if (k < 6) begin
                send_gap_pct = 52;
                recv_stall_pct = 14;
            end else begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            set_config(sweep_base[k], sweep_signed[k]);
            phase_chars = 0;
            while (phase_chars < CHARS_PER_PHASE) begin
                add_number();
            end
            add_end();
            drain();
        end

        if (fault_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
